@@ src/cied_pkg.sv @@
// Package for the closest-identifier edit distance block.
// Holds request codes, the cell token type and the case-folding function.
// No dependencies.
package cied_pkg;

  localparam int MAX_LEN_DEF     = 32;
  localparam int MAX_ENTRIES_DEF = 256;

  localparam int FUNC_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 8;
  localparam int DIST_W  = 6;
  localparam int EDITS_W = 6;
  localparam logic [EDITS_W-1:0] MAX_EDITS_RST = EDITS_W'(3);

  typedef enum logic [FUNC_W-1:0] {
    FN_QUERY    = 3'd0,
    FN_CAND     = 3'd1,
    FN_END_CAND = 3'd2,
    FN_END_LIST = 3'd3,
    FN_SKIP     = 3'd4
  } func_t;

  // Token that travels down the cell row.
  typedef enum logic [1:0] {
    TK_NONE,
    TK_UPDATE,
    TK_RESTART,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [CHAR_W-1:0] ch;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

@@ src/cied_if.sv @@
// Request and response channel interfaces for the edit distance block.
// Depends on cied_pkg.
interface cied_req_if;
  import cied_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] ch;
  modport source (output valid, func, ch, input ready);
  modport sink   (input valid, func, ch, output ready);
endinterface

interface cied_rsp_if;
  import cied_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_distance;
  logic              truncated;
  modport source (output valid, found, best_index, best_distance, truncated, input ready);
  modport sink   (input valid, found, best_index, best_distance, truncated, output ready);
endinterface

@@ src/cied_cell.sv @@
// One cell of the edit distance row: one query letter and one column entry.
// Depends on cied_pkg.
module cied_cell #(
  parameter int MAX_LEN = cied_pkg::MAX_LEN_DEF,
  parameter int IDX     = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cied_pkg::cell_ctl_t                    in_ctl,
  input  logic [$clog2(MAX_LEN+1)-1:0]           in_left,
  input  logic [$clog2(MAX_LEN+1)-1:0]           in_diag,
  input  logic [$clog2(MAX_LEN+1)-1:0]           in_q,
  input  logic [cied_pkg::IDX_W-1:0]             in_idx,
  input  logic                                   qwr_en,
  input  logic [cied_pkg::CHAR_W-1:0]            qwr_ch,
  output cied_pkg::cell_ctl_t                    out_ctl,
  output logic [$clog2(MAX_LEN+1)-1:0]           out_left,
  output logic [$clog2(MAX_LEN+1)-1:0]           out_diag,
  output logic [$clog2(MAX_LEN+1)-1:0]           out_q,
  output logic [cied_pkg::IDX_W-1:0]             out_idx,
  output logic                                   cap_valid,
  output logic                                   cap_ok,
  output logic [$clog2(MAX_LEN+1)-1:0]           cap_dist,
  output logic [cied_pkg::IDX_W-1:0]             cap_idx
);
  import cied_pkg::*;

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int LIM = IDX / 2 + 1;   // distance limit when this cell ends the query

  logic [CHAR_W-1:0] qchar;
  logic [LW-1:0]     val;
  logic [LW:0]       up1, left1, diag1, best;

  // DP update: min(up+1, left+1, diag+mismatch)
  always_comb begin
    up1   = {1'b0, val} + 1'b1;
    left1 = {1'b0, in_left} + 1'b1;
    diag1 = {1'b0, in_diag} + {{LW{1'b0}}, (qchar != in_ctl.ch)};
    best  = up1;
    if (left1 < best) begin
      best = left1;
    end
    if (diag1 < best) begin
      best = diag1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val         <= LW'(IDX);
      out_ctl     <= '{kind: TK_NONE, ch: '0};
      cap_valid   <= 1'b0;
    end else begin
      out_ctl   <= in_ctl;
      cap_valid <= (in_ctl.kind == TK_END) && (in_q == LW'(IDX));
      unique case (in_ctl.kind)
        TK_UPDATE:  val <= best[LW-1:0];
        TK_RESTART: val <= LW'(IDX);
        TK_END:     val <= LW'(IDX);
        TK_NONE:    val <= val;
        default:    val <= val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_left <= best[LW-1:0];
    out_diag <= val;
    out_q    <= in_q;
    out_idx  <= in_idx;
    cap_dist <= val;
    cap_ok   <= ({1'b0, val} <= (LW+1)'(LIM));
    cap_idx  <= in_idx;
    if (qwr_en) begin
      qchar <= fold_case(qwr_ch);
    end
  end

endmodule

@@ src/cied_best.sv @@
// Best-candidate tracker: keeps the earliest candidate of smallest distance.
// Depends on cied_pkg.
module cied_best #(
  parameter int MAX_LEN = cied_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          cand_valid,
  input  logic                          cand_ok,
  input  logic [$clog2(MAX_LEN+1)-1:0]  cand_dist,
  input  logic [cied_pkg::IDX_W-1:0]    cand_idx,
  output logic                          have_best,
  output logic [$clog2(MAX_LEN+1)-1:0]  best_dist,
  output logic [cied_pkg::IDX_W-1:0]    best_idx
);
  import cied_pkg::*;

  logic take;

  assign take = cand_valid && cand_ok && (!have_best || cand_dist < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_dist <= '0;
      best_idx  <= '0;
    end else if (clear) begin
      have_best <= 1'b0;
      best_dist <= '0;
      best_idx  <= '0;
    end else if (take) begin
      have_best <= 1'b1;
      best_dist <= cand_dist;
      best_idx  <= cand_idx;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_no_cand: assert property (@(posedge clk) disable iff (rst)
    clear |-> !cand_valid) else $error("candidate judged during list clear");
  a_take_sets: assert property (@(posedge clk) disable iff (rst)
    take && !clear |=> have_best && best_dist == $past(cand_dist))
    else $error("best not updated");
  a_monotone: assert property (@(posedge clk) disable iff (rst)
    have_best && !clear |=> have_best && best_dist <= $past(best_dist))
    else $error("best distance grew");
`endif

endmodule

@@ src/closest_identifier_edit_distance.sv @@
// Closest-identifier search by case-insensitive Levenshtein distance.
// Query, candidate and skip requests: one per cycle; a candidate byte enters
// a skewed row of MAX_LEN cells and is passed on from cell to cell.
// End candidate: distance captured at the query's last cell, then judged.
// End list: waits for every judged candidate to leave the row and for a free
// response slot; response appears the next cycle. Sync reset, max_edits=3.
module closest_identifier_edit_distance #(
  parameter int MAX_LEN     = cied_pkg::MAX_LEN_DEF,
  parameter int MAX_ENTRIES = cied_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  cied_req_if.sink                    req,
  cied_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [cied_pkg::EDITS_W-1:0] cfg_wdata
);
  import cied_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);       // column values, lengths
  localparam int EW = $clog2(MAX_ENTRIES + 1);   // list position, saturating
  localparam int PW = $clog2(MAX_LEN + 2);       // end tokens in flight
  localparam int CW = (LW > EDITS_W) ? LW : EDITS_W;

  // ---------------------------------------------------------------
  // Search state held at the head of the row
  // ---------------------------------------------------------------
  logic [EDITS_W-1:0] max_edits;
  logic [LW-1:0]      qlen, qlen_next;
  logic [LW-1:0]      cand_len, cand_len_next;
  logic [EW-1:0]      entry_cnt, entry_cnt_next;
  logic               overflow, overflow_next;
  logic [PW-1:0]      pending, pending_next;

  logic  acc, clear, qwr, imm;
  func_t func;

  // Head token feeding cell 1 (index 0 of the chain arrays is the head)
  cell_ctl_t         ctl_c  [0:MAX_LEN];
  logic [LW-1:0]     left_c [0:MAX_LEN];
  logic [LW-1:0]     diag_c [0:MAX_LEN];
  logic [LW-1:0]     q_c    [0:MAX_LEN];
  logic [IDX_W-1:0]  idx_c  [0:MAX_LEN];

  logic [MAX_LEN:1]  cap_v;
  logic              cap_ok_c [1:MAX_LEN];
  logic [LW-1:0]     cap_d_c  [1:MAX_LEN];
  logic [IDX_W-1:0]  cap_i_c  [1:MAX_LEN];

  logic              cap_any, cap_ok;
  logic [LW-1:0]     cap_dist;
  logic [IDX_W-1:0]  cap_idx;

  logic              j_valid, j_ok;
  logic [LW-1:0]     j_dist;
  logic [IDX_W-1:0]  j_idx;
  logic              have_best;
  logic [LW-1:0]     best_dist;
  logic [IDX_W-1:0]  best_idx;

  logic              entry_room, list_end_ok;

  assign func        = func_t'(req.func);
  assign entry_room  = entry_cnt < EW'(MAX_ENTRIES);
  // End of list must wait for all end tokens to be judged and a free response slot.
  assign list_end_ok = (pending == '0) && (!rsp.valid || rsp.ready);
  assign req.ready   = (func != FN_END_LIST) || list_end_ok;
  assign acc         = req.valid && req.ready;

  // ---------------------------------------------------------------
  // Request decode: head token and head state
  // ---------------------------------------------------------------
  always_comb begin
    ctl_c[0]       = '{kind: TK_NONE, ch: fold_case(req.ch)};
    left_c[0]      = cand_len + 1'b1;
    diag_c[0]      = cand_len;
    q_c[0]         = qlen;
    idx_c[0]       = IDX_W'(entry_cnt);
    qlen_next      = qlen;
    cand_len_next  = cand_len;
    entry_cnt_next = entry_cnt;
    overflow_next  = overflow;
    qwr            = 1'b0;
    imm            = 1'b0;
    clear          = 1'b0;
    if (acc) begin
      unique case (func)
        FN_QUERY: begin
          ctl_c[0].kind = TK_RESTART;
          cand_len_next = '0;
          if (qlen < LW'(MAX_LEN)) begin
            qwr       = 1'b1;
            qlen_next = qlen + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
        end
        FN_CAND: begin
          if (cand_len < LW'(MAX_LEN)) begin
            ctl_c[0].kind = TK_UPDATE;
            cand_len_next = cand_len + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
        end
        FN_END_CAND: begin
          cand_len_next = '0;
          // An empty query reads column entry 0 (the candidate length) at once.
          if (entry_room && qlen != '0) begin
            ctl_c[0].kind = TK_END;
          end else begin
            ctl_c[0].kind = TK_RESTART;
          end
          imm = entry_room && (qlen == '0);
          if (entry_room) begin
            entry_cnt_next = entry_cnt + 1'b1;
          end
        end
        FN_END_LIST: begin
          ctl_c[0].kind  = TK_RESTART;
          clear          = 1'b1;
          qlen_next      = '0;
          cand_len_next  = '0;
          entry_cnt_next = '0;
          overflow_next  = 1'b0;
        end
        FN_SKIP: begin
          ctl_c[0].kind = TK_RESTART;
          cand_len_next = '0;
          if (entry_room) begin
            entry_cnt_next = entry_cnt + 1'b1;
          end
        end
        default: begin
          ctl_c[0].kind = TK_NONE;
        end
      endcase
    end
  end

  // End tokens in the row: counted on issue, released on capture.
  always_comb begin
    pending_next = pending;
    if ((ctl_c[0].kind == TK_END) && !cap_any) begin
      pending_next = pending + 1'b1;
    end else if ((ctl_c[0].kind != TK_END) && cap_any) begin
      pending_next = pending - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_edits <= MAX_EDITS_RST;
      qlen      <= '0;
      cand_len  <= '0;
      entry_cnt <= '0;
      overflow  <= 1'b0;
      pending   <= '0;
    end else begin
      if (cfg_we) begin
        max_edits <= cfg_wdata;
      end
      qlen      <= qlen_next;
      cand_len  <= cand_len_next;
      entry_cnt <= entry_cnt_next;
      overflow  <= overflow_next;
      pending   <= pending_next;
    end
  end

  // ---------------------------------------------------------------
  // Cell row: cell k holds query letter k-1 and column entry k
  // ---------------------------------------------------------------
  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    cied_cell #(.MAX_LEN(MAX_LEN), .IDX(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_ctl    (ctl_c[k-1]),
      .in_left   (left_c[k-1]),
      .in_diag   (diag_c[k-1]),
      .in_q      (q_c[k-1]),
      .in_idx    (idx_c[k-1]),
      .qwr_en    (qwr && (qlen == LW'(k-1))),
      .qwr_ch    (req.ch),
      .out_ctl   (ctl_c[k]),
      .out_left  (left_c[k]),
      .out_diag  (diag_c[k]),
      .out_q     (q_c[k]),
      .out_idx   (idx_c[k]),
      .cap_valid (cap_v[k]),
      .cap_ok    (cap_ok_c[k]),
      .cap_dist  (cap_d_c[k]),
      .cap_idx   (cap_i_c[k])
    );
  end

  // At most one cell captures per cycle; merge by masked OR.
  always_comb begin
    cap_any  = 1'b0;
    cap_ok   = 1'b0;
    cap_dist = '0;
    cap_idx  = '0;
    for (int k = 1; k <= MAX_LEN; k++) begin
      cap_any  = cap_any | cap_v[k];
      cap_ok   = cap_ok | (cap_v[k] & cap_ok_c[k]);
      cap_dist = cap_dist | (cap_d_c[k] & {LW{cap_v[k]}});
      cap_idx  = cap_idx | (cap_i_c[k] & {IDX_W{cap_v[k]}});
    end
  end

  // Judge input: row capture, or immediate read for an empty query (limit 1).
  always_comb begin
    j_valid = cap_any || imm;
    if (imm) begin
      j_ok   = cand_len <= LW'(1);
      j_dist = cand_len;
      j_idx  = IDX_W'(entry_cnt);
    end else begin
      j_ok   = cap_ok;
      j_dist = cap_dist;
      j_idx  = cap_idx;
    end
  end

  cied_best #(.MAX_LEN(MAX_LEN)) u_best (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .cand_valid (j_valid),
    .cand_ok    (j_ok),
    .cand_dist  (j_dist),
    .cand_idx   (j_idx),
    .have_best  (have_best),
    .best_dist  (best_dist),
    .best_idx   (best_idx)
  );

  // ---------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (clear) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      rsp.found         <= have_best && (CW'(best_dist) <= CW'(max_edits));
      rsp.best_index    <= have_best ? best_idx : '0;
      rsp.best_distance <= have_best ? DIST_W'(best_dist) : '0;
      rsp.truncated     <= overflow;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_list_drained: assert property (@(posedge clk) disable iff (rst)
    acc && func == FN_END_LIST |-> pending == '0)
    else $error("end of list taken with candidates in flight");
  a_cap_counted: assert property (@(posedge clk) disable iff (rst)
    cap_any |-> pending != '0)
    else $error("capture without pending end token");
  a_cap_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cap_v)) else $error("two cells captured at once");
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    acc && func == FN_END_LIST |=> rsp.valid)
    else $error("end of list gave no response");
`endif

endmodule

@@ test/closest_identifier_edit_distance_tb.sv @@
// Self-checking testbench for closest_identifier_edit_distance.
// Directed table plus random word lists, scored by a built-in edit distance predictor.
// Depends on cied_pkg, cied_if.sv and the block itself.
module closest_identifier_edit_distance_tb;
  import cied_pkg::*;

  localparam int MAX_LEN       = MAX_LEN_DEF;
  localparam int MAX_ENTRIES   = MAX_ENTRIES_DEF;
  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = MAX_LEN + 8;  // lets the cell row flush after the last response
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_ITEMS    = 500;
  localparam int MIN_LISTS     = 12;
  localparam int N_PHASES      = 8;
  localparam int LIMIT_CYCLES  = 400000;
  // codes 5..7 have no meaning and must be ignored
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED    = 3'd7;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] edits;
    logic              trunc;
  } match_t;

  // one directed row: a request repeated reps times, optionally with a hand-typed answer
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    int                reps;
    bit                typed;
    match_t            want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [EDITS_W-1:0] cfg_wdata;

  cied_req_if req_ch();
  cied_rsp_if rsp_ch();

  closest_identifier_edit_distance dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: query word, one DP column over it, list bookkeeping.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] q_word [MAX_LEN];
  int                q_len;
  int                col [MAX_LEN+1];
  int                c_len;
  int                pos;        // list position, saturates at MAX_ENTRIES
  int                best_pos;
  int                best_cost;
  bit                have_best;
  bit                overflow;   // some word ran past MAX_LEN since the last end of list
  int                edit_limit; // shadow of max_edits

  match_t    expected_matches [$];
  stim_row_t dir_rows [$];
  int        err_count;
  int        lists_sent;
  int        items_sent;
  bit        src_gap_on;
  bit        sink_gap_on;
  bit        hold_req;

  // only A-Z fold; '@', '[', '`', '{' stay apart
  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic void restart_column();
    for (int i = 0; i <= MAX_LEN; i++) begin
      col[i] = i;
    end
    c_len = 0;
  endfunction

  function automatic void clear_search();
    q_len     = 0;
    pos       = 0;
    best_pos  = 0;
    best_cost = 0;
    have_best = 1'b0;
    overflow  = 1'b0;
    restart_column();
  endfunction

  // Advance the model by one accepted request; returns 1 when it yields a response.
  function automatic bit predict_search(input logic [FUNC_W-1:0] f,
                                        input logic [CHAR_W-1:0] c, output match_t m);
    int i;
    int diag;
    int up;
    int b;
    int a;
    int d;
    bit has_out;
    m = '0;
    has_out = 1'b0;
    case (f)
      FN_QUERY: begin
        if (q_len >= MAX_LEN) begin
          overflow = 1'b1;
        end else begin
          q_word[q_len] = c;
          q_len++;
        end
        restart_column();  // a partial candidate is thrown away
      end
      FN_CAND: begin
        if (c_len >= MAX_LEN) begin
          overflow = 1'b1;
        end else begin
          c_len++;
          diag = col[0];
          col[0] = c_len;
          for (i = 1; i <= q_len; i++) begin
            up = col[i];
            b = up + 1;
            if (col[i-1] + 1 < b) b = col[i-1] + 1;
            a = diag + ((lower_ascii(q_word[i-1]) == lower_ascii(c)) ? 0 : 1);
            if (a < b) b = a;
            col[i] = b;
            diag = up;
          end
        end
      end
      FN_END_CAND: begin
        d = col[q_len];
        // strictly better only, and no worse than half the query plus one
        if (pos < MAX_ENTRIES && (!have_best || d < best_cost) && d <= q_len / 2 + 1) begin
          have_best = 1'b1;
          best_cost = d;
          best_pos  = pos;
        end
        if (pos < MAX_ENTRIES) pos++;
        restart_column();
      end
      FN_END_LIST: begin
        m.found = have_best && best_cost <= edit_limit;
        m.idx   = have_best ? IDX_W'(best_pos) : '0;
        m.edits = have_best ? DIST_W'(best_cost) : '0;
        m.trunc = overflow;
        has_out = 1'b1;
        clear_search();
      end
      FN_SKIP: begin
        if (pos < MAX_ENTRIES) pos++;
        restart_column();
      end
      default: begin
      end
    endcase
    return has_out;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("closest_identifier_edit_distance_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: random ready bursts, plus one long hold-off on request so
  // the block backs up and stalls its request channel.
  // ---------------------------------------------------------------------------
  initial begin : response_sink
    int stall;
    bit hold_taken;
    stall = 0;
    hold_taken = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && sink_gap_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // every accepted response is matched against the oldest expectation
  always @(posedge clk) begin : response_check
    match_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("response with nothing pending", 1, 0);
      end else begin
        want = expected_matches.pop_front();
        if (rsp_ch.found !== want.found)
          report_mismatch("found", rsp_ch.found, want.found);
        if (rsp_ch.best_index !== want.idx)
          report_mismatch("best_index", rsp_ch.best_index, want.idx);
        if (rsp_ch.best_distance !== want.edits)
          report_mismatch("best_distance", rsp_ch.best_distance, want.edits);
        if (rsp_ch.truncated !== want.trunc)
          report_mismatch("truncated", rsp_ch.truncated, want.trunc);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request (after an optional idle burst), wait for the handshake,
  // then run the predictor. Valid is left high so back-to-back requests stream.
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                          input bit typed, input match_t want);
    match_t got;
    int gap;
    if (src_gap_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.ch    <= c;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (predict_search(f, c, got)) begin
      expected_matches.push_back(typed ? want : got);
      lists_sent++;
    end
    if (f <= FN_SKIP) items_sent++;
  endtask

  task automatic send(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c);
    send_req(f, c, 1'b0, '0);
  endtask

  // drop valid, let every response come back, then let the cell row flush
  task automatic wait_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= EDITS_W'(v);
    @(posedge clk);
    edit_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                         input int reps, input bit typed = 1'b0, input match_t want = '0);
    stim_row_t r;
    r.func  = f;
    r.ch    = c;
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  // mostly a few letters in both cases so distances stay small; some fold
  // boundary bytes; some anything at all
  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] c;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      c = 8'h61 + CHAR_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) c = c - 8'd32;
    end else if (r < 8) begin
      case ($urandom_range(0, 7))
        0: c = 8'h40;
        1: c = 8'h5B;
        2: c = 8'h60;
        3: c = 8'h7B;
        4: c = 8'h41;
        5: c = 8'h5A;
        6: c = 8'h61;
        default: c = 8'h7A;
      endcase
    end else begin
      c = CHAR_W'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // One query plus a short list of candidates, most of them near misses of
  // the query, with skips, junk codes, stray query bytes and partial words mixed in.
  task automatic gen_list();
    logic [CHAR_W-1:0] word [$];
    logic [CHAR_W-1:0] cand [$];
    int n;
    int p;
    int kind;
    word = {};
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 2)
                                     : $urandom_range(1, 6);
    repeat (n) word.push_back(pick_char());
    foreach (word[i]) send(FN_QUERY, word[i]);
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send(FN_SKIP, CHAR_W'($urandom_range(0, 255)));
      end else if (kind == 1) begin
        send(FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED)), CHAR_W'($urandom_range(0, 255)));
      end else if (kind == 2) begin
        send(FN_END_CAND, CHAR_W'($urandom_range(0, 255)));  // empty candidate
      end else begin
        cand = word;
        repeat ($urandom_range(0, 3)) begin
          p = $urandom_range(0, cand.size());
          case ($urandom_range(0, 2))
            0: cand.insert(p, pick_char());
            1: if (p < cand.size()) cand.delete(p);
            default: if (p < cand.size()) cand[p] = pick_char();
          endcase
        end
        foreach (cand[i]) begin
          if (lower_ascii(cand[i]) >= 8'h61 && lower_ascii(cand[i]) <= 8'h7A &&
              $urandom_range(0, 3) == 0)
            cand[i] = cand[i] ^ 8'h20;
        end
        foreach (cand[i]) send(FN_CAND, cand[i]);
        if (kind == 3) begin
          // query grows mid list: candidate dropped, then judged empty
          send(FN_QUERY, pick_char());
          send(FN_END_CAND, 8'h00);
        end else if (kind == 4) begin
          send(FN_SKIP, 8'h00);  // partial candidate discarded
        end else begin
          send(FN_END_CAND, CHAR_W'($urandom_range(0, 255)));
        end
      end
    end
    if ($urandom_range(0, 7) == 0) send(FN_CAND, pick_char());  // left open at end of list
    send(FN_END_LIST, CHAR_W'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func  = '0;
    req_ch.ch    = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    err_count    = 0;
    lists_sent   = 0;
    items_sent   = 0;
    src_gap_on   = 1'b1;
    sink_gap_on  = 1'b1;
    hold_req     = 1'b0;
    edit_limit   = MAX_EDITS_RST;
    clear_search();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, max_edits at its reset value.
    // empty list straight out of reset
    add_row(FN_END_LIST, 8'h00, 1, 1'b1, match_t'{1'b0, 8'd0, 6'd0, 1'b0});
    // "Ab" vs "aB": exact match through case folding, then a skip and a worse word
    add_row(FN_QUERY, 8'h41, 1);
    add_row(FN_QUERY, 8'h62, 1);
    add_row(FN_CAND, 8'h61, 1);
    add_row(FN_CAND, 8'h42, 1);
    add_row(FN_END_CAND, 8'hFF, 1);
    add_row(FN_SKIP, 8'h00, 1);
    add_row(FN_CAND, 8'h00, 1);
    add_row(FN_CAND, 8'hFF, 1);
    add_row(FN_END_CAND, 8'h00, 1);
    add_row(FN_UNUSED, 8'hFF, 1);
    add_row(FN_END_LIST, 8'h00, 1, 1'b1, match_t'{1'b1, 8'd0, 6'd0, 1'b0});
    // "@[" vs empty word then "`{": no folding outside A-Z, tie keeps the first
    add_row(FN_QUERY, 8'h40, 1);
    add_row(FN_QUERY, 8'h5B, 1);
    add_row(FN_END_CAND, 8'h00, 1);
    add_row(FN_CAND, 8'h60, 1);
    add_row(FN_CAND, 8'h7B, 1);
    add_row(FN_END_CAND, 8'h00, 1);
    add_row(FN_END_LIST, 8'h00, 1, 1'b1, match_t'{1'b1, 8'd0, 6'd2, 1'b0});
    // over-long query and candidate: extra bytes dropped, truncation flagged
    add_row(FN_QUERY, 8'hFF, MAX_LEN + 1);
    add_row(FN_CAND, 8'hFF, MAX_LEN + 1);
    add_row(FN_END_CAND, 8'h00, 1);
    add_row(FN_END_LIST, 8'h00, 1, 1'b1, match_t'{1'b1, 8'd0, 6'd0, 1'b1});
    // last counted position, then entries past the table end are ignored
    add_row(FN_QUERY, 8'h71, 1);
    add_row(FN_SKIP, 8'h00, MAX_ENTRIES - 1);
    add_row(FN_CAND, 8'h51, 1);
    add_row(FN_END_CAND, 8'h00, 1);
    add_row(FN_CAND, 8'h71, 1);
    add_row(FN_END_CAND, 8'h00, 1);
    add_row(FN_SKIP, 8'hFF, 2);
    add_row(FN_END_LIST, 8'h00, 1, 1'b1, match_t'{1'b1, 8'd255, 6'd0, 1'b0});

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps)
        send_req(dir_rows[r].func, dir_rows[r].ch, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random part in phases; each phase starts idle with a new max_edits.
    // Both extremes of max_edits come first. Phase 2 also triggers the long
    // response hold-off. The last phase runs with no idling at all.
    lists_sent = 0;
    items_sent = 0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drain();
      write_limit(ph == 0 ? 0 : (ph == 1 ? 32 : $urandom_range(0, 32)));
      src_gap_on  = (ph < N_PHASES - 1) && (ph % 3 != 2);
      sink_gap_on = (ph < N_PHASES - 1) && (ph % 3 != 1);
      if (ph == 2) hold_req = 1'b1;
      while (items_sent < (ph + 1) * RAND_ITEMS / N_PHASES ||
             (ph == N_PHASES - 1 && lists_sent < MIN_LISTS))
        gen_list();
    end

    wait_drain();
    if (err_count == 0) begin
      $display("closest_identifier_edit_distance_tb: done, clean");
    end else begin
      $display("closest_identifier_edit_distance_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ closest_identifier_edit_distance.f @@
src/cied_pkg.sv
src/cied_if.sv
src/cied_cell.sv
src/cied_best.sv
src/closest_identifier_edit_distance.sv
test/closest_identifier_edit_distance_tb.sv
